[src/sct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Key masks, token order, text table and queue entry type for the stenotype
// chord to text translator.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int CHORD_W   = 23;
  localparam int CHAR_W    = 7;
  localparam int MAX_CHARS = 21;
  localparam int TXT_LEN   = 12;
  localparam int TXT_W     = 8 * TXT_LEN;
  localparam int LEN_W     = $clog2(TXT_LEN + 1);
  localparam int CNT_W     = $clog2(MAX_CHARS);

  localparam logic [CHORD_W-1:0] K_NUM = 23'h000001;
  localparam logic [CHORD_W-1:0] K_IS  = 23'h000002;
  localparam logic [CHORD_W-1:0] K_IT  = 23'h000004;
  localparam logic [CHORD_W-1:0] K_IK  = 23'h000008;
  localparam logic [CHORD_W-1:0] K_IP  = 23'h000010;
  localparam logic [CHORD_W-1:0] K_IW  = 23'h000020;
  localparam logic [CHORD_W-1:0] K_IH  = 23'h000040;
  localparam logic [CHORD_W-1:0] K_IR  = 23'h000080;
  localparam logic [CHORD_W-1:0] K_A   = 23'h000100;
  localparam logic [CHORD_W-1:0] K_O   = 23'h000200;
  localparam logic [CHORD_W-1:0] K_ST  = 23'h000400;
  localparam logic [CHORD_W-1:0] K_E   = 23'h000800;
  localparam logic [CHORD_W-1:0] K_U   = 23'h001000;
  localparam logic [CHORD_W-1:0] K_FF  = 23'h002000;
  localparam logic [CHORD_W-1:0] K_FR  = 23'h004000;
  localparam logic [CHORD_W-1:0] K_FP  = 23'h008000;
  localparam logic [CHORD_W-1:0] K_FB  = 23'h010000;
  localparam logic [CHORD_W-1:0] K_FL  = 23'h020000;
  localparam logic [CHORD_W-1:0] K_FG  = 23'h040000;
  localparam logic [CHORD_W-1:0] K_FT  = 23'h080000;
  localparam logic [CHORD_W-1:0] K_FS  = 23'h100000;
  localparam logic [CHORD_W-1:0] K_FD  = 23'h200000;
  localparam logic [CHORD_W-1:0] K_FZ  = 23'h400000;

  localparam logic [CHORD_W-1:0] G_INIT = K_ST | K_IS | K_IT | K_IK | K_IP | K_IW | K_IH | K_IR;
  localparam logic [CHORD_W-1:0] G_VOW  = K_A | K_O | K_E | K_U;
  localparam logic [CHORD_W-1:0] G_FIN  = K_FF | K_FR | K_FP | K_FB | K_FL | K_FG | K_FT
                                          | K_FS | K_FD | K_FZ;

  // token order of one chord's text
  localparam int NUM_TOK   = 27;
  localparam int TOK_W     = $clog2(NUM_TOK);
  localparam int TOK_WHOLE = 0;
  localparam int TOK_HASH  = 1;
  localparam int TOK_INIT  = 2;
  localparam int TOK_IS    = 3;
  localparam int TOK_VOW   = 10;
  localparam int TOK_A     = 11;
  localparam int TOK_O     = 12;
  localparam int TOK_STAR  = 13;
  localparam int TOK_E     = 14;
  localparam int TOK_U     = 15;
  localparam int TOK_FIN   = 16;
  localparam int TOK_FF    = 17;

  typedef enum logic [6:0] {
    STR_COMMA, STR_CORR, STR_PARA, STR_PERIOD, STR_QUEST, STR_NEWLINE,
    STR_D0, STR_D1, STR_D2, STR_D3, STR_D4, STR_D5, STR_D6, STR_D7, STR_D8, STR_D9,
    STR_HASH,
    STR_IB, STR_ICH, STR_ID, STR_IF, STR_IG, STR_IJ, STR_IL, STR_IM, STR_IN, STR_IQU,
    STR_IV, STR_IY, STR_IZ,
    STR_IS, STR_IT, STR_IK, STR_IP, STR_IW, STR_IH, STR_IR,
    STR_AY, STR_AW, STR_EE, STR_I, STR_IYV, STR_OH, STR_OI, STR_OO, STR_OU, STR_UU,
    STR_A, STR_O, STR_STAR, STR_E, STR_U,
    STR_FCH, STR_FJ, STR_FK, STR_FM, STR_FMP, STR_FN, STR_FNG, STR_FRCH, STR_FRF,
    STR_FSH, STR_FX, STR_FSHUN,
    STR_FF, STR_FR, STR_FP, STR_FB, STR_FL, STR_FG, STR_FT, STR_FS, STR_FD, STR_FZ
  } str_id_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [TXT_W-1:0] text;
  } str_t;

  typedef struct packed {
    logic [NUM_TOK-1:0] mask;
    str_id_t            whole_id;
    str_id_t            init_id;
    str_id_t            vow_id;
    str_id_t            fin_id;
  } entry_t;

  function automatic str_t str_lookup(str_id_t id);
    str_t s;
    s.len  = LEN_W'(1);
    s.text = '0;
    unique case (id)
      STR_COMMA:   s.text = TXT_W'(",");
      STR_CORR:    begin s.len = LEN_W'(12); s.text = TXT_W'("[correction]"); end
      STR_PARA:    begin s.len = LEN_W'(11); s.text = TXT_W'("[paragraph]"); end
      STR_PERIOD:  s.text = TXT_W'(".");
      STR_QUEST:   s.text = TXT_W'("?");
      STR_NEWLINE: begin s.len = LEN_W'(9); s.text = TXT_W'("[newline]"); end
      STR_D0:      s.text = TXT_W'("0");
      STR_D1:      s.text = TXT_W'("1");
      STR_D2:      s.text = TXT_W'("2");
      STR_D3:      s.text = TXT_W'("3");
      STR_D4:      s.text = TXT_W'("4");
      STR_D5:      s.text = TXT_W'("5");
      STR_D6:      s.text = TXT_W'("6");
      STR_D7:      s.text = TXT_W'("7");
      STR_D8:      s.text = TXT_W'("8");
      STR_D9:      s.text = TXT_W'("9");
      STR_HASH:    s.text = TXT_W'("#");
      STR_IB:      s.text = TXT_W'("B");
      STR_ICH:     begin s.len = LEN_W'(2); s.text = TXT_W'("CH"); end
      STR_ID:      s.text = TXT_W'("D");
      STR_IF:      s.text = TXT_W'("F");
      STR_IG:      s.text = TXT_W'("G");
      STR_IJ:      s.text = TXT_W'("J");
      STR_IL:      s.text = TXT_W'("L");
      STR_IM:      s.text = TXT_W'("M");
      STR_IN:      s.text = TXT_W'("N");
      STR_IQU:     begin s.len = LEN_W'(2); s.text = TXT_W'("QU"); end
      STR_IV:      s.text = TXT_W'("V");
      STR_IY:      s.text = TXT_W'("Y");
      STR_IZ:      s.text = TXT_W'("Z");
      STR_IS:      s.text = TXT_W'("S");
      STR_IT:      s.text = TXT_W'("T");
      STR_IK:      s.text = TXT_W'("K");
      STR_IP:      s.text = TXT_W'("P");
      STR_IW:      s.text = TXT_W'("W");
      STR_IH:      s.text = TXT_W'("H");
      STR_IR:      s.text = TXT_W'("R");
      STR_AY:      begin s.len = LEN_W'(2); s.text = TXT_W'("ay"); end
      STR_AW:      begin s.len = LEN_W'(2); s.text = TXT_W'("aw"); end
      STR_EE:      begin s.len = LEN_W'(2); s.text = TXT_W'("ee"); end
      STR_I:       s.text = TXT_W'("i");
      STR_IYV:     begin s.len = LEN_W'(2); s.text = TXT_W'("iy"); end
      STR_OH:      begin s.len = LEN_W'(2); s.text = TXT_W'("oh"); end
      STR_OI:      begin s.len = LEN_W'(2); s.text = TXT_W'("oi"); end
      STR_OO:      begin s.len = LEN_W'(2); s.text = TXT_W'("oo"); end
      STR_OU:      begin s.len = LEN_W'(2); s.text = TXT_W'("ou"); end
      STR_UU:      begin s.len = LEN_W'(2); s.text = TXT_W'("uu"); end
      STR_A:       s.text = TXT_W'("a");
      STR_O:       s.text = TXT_W'("o");
      STR_STAR:    s.text = TXT_W'("*");
      STR_E:       s.text = TXT_W'("e");
      STR_U:       s.text = TXT_W'("u");
      STR_FCH:     begin s.len = LEN_W'(2); s.text = TXT_W'("ch"); end
      STR_FJ:      s.text = TXT_W'("j");
      STR_FK:      s.text = TXT_W'("k");
      STR_FM:      s.text = TXT_W'("m");
      STR_FMP:     begin s.len = LEN_W'(2); s.text = TXT_W'("mp"); end
      STR_FN:      s.text = TXT_W'("n");
      STR_FNG:     begin s.len = LEN_W'(2); s.text = TXT_W'("ng"); end
      STR_FRCH:    begin s.len = LEN_W'(3); s.text = TXT_W'("rch"); end
      STR_FRF:     begin s.len = LEN_W'(2); s.text = TXT_W'("rf"); end
      STR_FSH:     begin s.len = LEN_W'(2); s.text = TXT_W'("sh"); end
      STR_FX:      s.text = TXT_W'("x");
      STR_FSHUN:   begin s.len = LEN_W'(4); s.text = TXT_W'("shun"); end
      STR_FF:      s.text = TXT_W'("f");
      STR_FR:      s.text = TXT_W'("r");
      STR_FP:      s.text = TXT_W'("p");
      STR_FB:      s.text = TXT_W'("b");
      STR_FL:      s.text = TXT_W'("l");
      STR_FG:      s.text = TXT_W'("g");
      STR_FT:      s.text = TXT_W'("t");
      STR_FS:      s.text = TXT_W'("s");
      STR_FD:      s.text = TXT_W'("d");
      STR_FZ:      s.text = TXT_W'("z");
      default:     s.text = TXT_W'(" ");
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[src/sct_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sct_front
// Accepts a chord and classifies it into the list of text tokens it yields,
// one queue entry per nonempty chord.
// ----------------------------------------------------------------------------
module sct_front import sct_pkg::*; (
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CHORD_W-1:0] chord,
  input  wire logic               q_full,
  output logic                    push,
  output entry_t                  entry
);

  logic               accept;
  logic               whole_hit;
  logic               init_hit;
  logic               vow_hit;
  logic               fin_hit;
  logic [CHORD_W-1:0] ig;
  logic [CHORD_W-1:0] vg;
  logic [CHORD_W-1:0] fg;

  assign busy   = q_full;
  assign accept = start && !busy;
  assign ig     = chord & G_INIT;
  assign vg     = chord & G_VOW;
  assign fg     = chord & G_FIN;

  always_comb begin
    whole_hit      = 1'b1;
    entry.whole_id = STR_HASH;
    unique case (chord)
      K_FR | K_FB | K_FG | K_FS: entry.whole_id = STR_COMMA;
      K_ST:                      entry.whole_id = STR_CORR;
      K_IP | K_FF:               entry.whole_id = STR_PARA;
      K_FF | K_FP | K_FL | K_FT: entry.whole_id = STR_PERIOD;
      K_IS | K_IT | K_IP | K_IH: entry.whole_id = STR_QUEST;
      K_IP | K_IR | K_A | K_FF:  entry.whole_id = STR_NEWLINE;
      K_NUM | K_O:               entry.whole_id = STR_D0;
      K_NUM | K_IS:              entry.whole_id = STR_D1;
      K_NUM | K_IT:              entry.whole_id = STR_D2;
      K_NUM | K_IP:              entry.whole_id = STR_D3;
      K_NUM | K_IH:              entry.whole_id = STR_D4;
      K_NUM | K_A:               entry.whole_id = STR_D5;
      K_NUM | K_FF:              entry.whole_id = STR_D6;
      K_NUM | K_FP:              entry.whole_id = STR_D7;
      K_NUM | K_FL:              entry.whole_id = STR_D8;
      K_NUM | K_FT:              entry.whole_id = STR_D9;
      default:                   whole_hit = 1'b0;
    endcase

    init_hit      = 1'b1;
    entry.init_id = STR_HASH;
    unique case (ig)
      K_IP | K_IW:               entry.init_id = STR_IB;
      K_IK | K_IH:               entry.init_id = STR_ICH;
      K_IT | K_IK:               entry.init_id = STR_ID;
      K_IT | K_IP:               entry.init_id = STR_IF;
      K_IT | K_IK | K_IP | K_IW: entry.init_id = STR_IG;
      K_IS | K_IK | K_IW | K_IR: entry.init_id = STR_IJ;
      K_IH | K_IR:               entry.init_id = STR_IL;
      K_IP | K_IH:               entry.init_id = STR_IM;
      K_IT | K_IP | K_IH:        entry.init_id = STR_IN;
      K_IK | K_IW:               entry.init_id = STR_IQU;
      K_IS | K_IR:               entry.init_id = STR_IV;
      K_IK | K_IW | K_IR:        entry.init_id = STR_IY;
      K_IS | K_ST:               entry.init_id = STR_IZ;
      default:                   init_hit = 1'b0;
    endcase

    vow_hit      = 1'b1;
    entry.vow_id = STR_HASH;
    unique case (vg)
      K_A | K_E | K_U:       entry.vow_id = STR_AY;
      K_A | K_U:             entry.vow_id = STR_AW;
      K_A | K_O | K_E:       entry.vow_id = STR_EE;
      K_E | K_U:             entry.vow_id = STR_I;
      K_A | K_O | K_E | K_U: entry.vow_id = STR_IYV;
      K_O | K_E:             entry.vow_id = STR_OH;
      K_O | K_E | K_U:       entry.vow_id = STR_OI;
      K_A | K_O:             entry.vow_id = STR_OO;
      K_O | K_U:             entry.vow_id = STR_OU;
      K_A | K_O | K_U:       entry.vow_id = STR_UU;
      default:               vow_hit = 1'b0;
    endcase

    // star is always released before the finals
    fin_hit      = 1'b1;
    entry.fin_id = STR_HASH;
    unique case (fg)
      K_FF | K_FP:                entry.fin_id = STR_FCH;
      K_FP | K_FB | K_FL | K_FG:  entry.fin_id = STR_FJ;
      K_FB | K_FG:                entry.fin_id = STR_FK;
      K_FP | K_FL:                entry.fin_id = STR_FM;
      K_FF | K_FR | K_FP:         entry.fin_id = STR_FMP;
      K_FP | K_FB:                entry.fin_id = STR_FN;
      K_FP | K_FB | K_FG:         entry.fin_id = STR_FNG;
      K_FF | K_FR | K_FP | K_FB:  entry.fin_id = STR_FRCH;
      K_FF | K_FR | K_FB:         entry.fin_id = STR_FRF;
      K_FR | K_FB:                entry.fin_id = STR_FSH;
      K_FB | K_FG | K_FS:         entry.fin_id = STR_FX;
      K_FG | K_FS:                entry.fin_id = STR_FSHUN;
      default:                    fin_hit = 1'b0;
    endcase

    entry.mask = '0;
    if (whole_hit) begin
      entry.mask[TOK_WHOLE] = 1'b1;
    end else begin
      entry.mask[TOK_HASH] = chord[0];
      if (init_hit) begin
        entry.mask[TOK_INIT] = 1'b1;
      end else begin
        entry.mask[TOK_IS +: 7] = chord[7:1];
      end
      if (vow_hit) begin
        entry.mask[TOK_VOW] = 1'b1;
      end else begin
        entry.mask[TOK_A] = chord[8];
        entry.mask[TOK_O] = chord[9];
        entry.mask[TOK_E] = chord[11];
        entry.mask[TOK_U] = chord[12];
      end
      entry.mask[TOK_STAR] = chord[10] && !init_hit;
      if (fin_hit) begin
        entry.mask[TOK_FIN] = 1'b1;
      end else begin
        entry.mask[TOK_FF +: 10] = chord[22:13];
      end
    end
  end

  // an empty chord yields no text
  assign push = accept && (entry.mask != '0);

endmodule
`default_nettype wire

[src/sct_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sct_queue
// Short register queue of classified chords between front and back end.
// ----------------------------------------------------------------------------
module sct_queue import sct_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output entry_t      pop_data,
  output logic        full,
  output logic        empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[src/sct_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sct_back
// Walks the tokens of one classified chord and sends its text one character
// per cycle, marking the final character.
// ----------------------------------------------------------------------------
module sct_back import sct_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire entry_t       q_data,
  output logic              q_pop,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last_char
);

  logic               act_r, act_nxt;
  entry_t             ent_r, ent_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  logic [TOK_W-1:0]   tok;
  str_id_t            cur_id;
  str_t               cur;
  logic [LEN_W-1:0]   pos;
  logic [TXT_W-1:0]   shifted;
  logic               str_end;
  logic [NUM_TOK-1:0] rest;
  logic               last;
  logic               done;

  always_comb begin
    tok = '0;
    for (int i = NUM_TOK - 1; i >= 0; i--) begin
      if (ent_r.mask[i]) begin
        tok = TOK_W'(i);
      end
    end
  end

  always_comb begin
    unique case (tok)
      TOK_W'(TOK_WHOLE):   cur_id = ent_r.whole_id;
      TOK_W'(TOK_HASH):    cur_id = STR_HASH;
      TOK_W'(TOK_INIT):    cur_id = ent_r.init_id;
      TOK_W'(TOK_IS):      cur_id = STR_IS;
      TOK_W'(TOK_IS + 1):  cur_id = STR_IT;
      TOK_W'(TOK_IS + 2):  cur_id = STR_IK;
      TOK_W'(TOK_IS + 3):  cur_id = STR_IP;
      TOK_W'(TOK_IS + 4):  cur_id = STR_IW;
      TOK_W'(TOK_IS + 5):  cur_id = STR_IH;
      TOK_W'(TOK_IS + 6):  cur_id = STR_IR;
      TOK_W'(TOK_VOW):     cur_id = ent_r.vow_id;
      TOK_W'(TOK_A):       cur_id = STR_A;
      TOK_W'(TOK_O):       cur_id = STR_O;
      TOK_W'(TOK_STAR):    cur_id = STR_STAR;
      TOK_W'(TOK_E):       cur_id = STR_E;
      TOK_W'(TOK_U):       cur_id = STR_U;
      TOK_W'(TOK_FIN):     cur_id = ent_r.fin_id;
      TOK_W'(TOK_FF):      cur_id = STR_FF;
      TOK_W'(TOK_FF + 1):  cur_id = STR_FR;
      TOK_W'(TOK_FF + 2):  cur_id = STR_FP;
      TOK_W'(TOK_FF + 3):  cur_id = STR_FB;
      TOK_W'(TOK_FF + 4):  cur_id = STR_FL;
      TOK_W'(TOK_FF + 5):  cur_id = STR_FG;
      TOK_W'(TOK_FF + 6):  cur_id = STR_FT;
      TOK_W'(TOK_FF + 7):  cur_id = STR_FS;
      TOK_W'(TOK_FF + 8):  cur_id = STR_FD;
      TOK_W'(TOK_FF + 9):  cur_id = STR_FZ;
      default:             cur_id = STR_HASH;
    endcase
  end

  assign cur     = str_lookup(cur_id);
  assign pos     = cur.len - LEN_W'(1) - idx_r;
  assign shifted = cur.text >> {pos, 3'b000};
  assign str_end = (idx_r == cur.len - LEN_W'(1));
  assign rest    = ent_r.mask & ~(NUM_TOK'(1) << tok);
  assign last    = (str_end && (rest == '0)) || (cnt_r == CNT_W'(MAX_CHARS - 1));
  assign done    = act_r && last;
  assign q_pop   = (!act_r || done) && !q_empty;

  always_comb begin
    act_nxt = act_r;
    ent_nxt = ent_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    if (!act_r || done) begin
      act_nxt = !q_empty;
      ent_nxt = q_data;
      idx_nxt = '0;
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
      if (str_end) begin
        idx_nxt    = '0;
        ent_nxt.mask = rest;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= shifted[CHAR_W-1:0];
    out_last_r <= last;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule
`default_nettype wire

[src/steno_chord_to_text.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// steno_chord_to_text
// Translates one 23-key stenotype chord into ASCII text, one character per
// out_valid strobe, with out_last_char on the final character.
// A chord passes through the queue into the text unit, and each character is
// registered onto the outputs. Throughput: one character per cycle; a chord
// gives 1 to 21 characters, and queued chords follow with no gap between them.
// busy is high while the 2-entry chord queue (QUEUE_DEPTH) is full.
// Reset clears the queue, the text unit and the out_valid strobe.
// ----------------------------------------------------------------------------
module steno_chord_to_text import sct_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CHORD_W-1:0] in_chord,
  output logic                    out_valid,
  output logic [CHAR_W-1:0]       out_char_code,
  output logic                    out_last_char
);

  logic   q_full;
  logic   q_empty;
  logic   q_push;
  logic   q_pop;
  entry_t q_wdata;
  entry_t q_rdata;

  sct_front u_front (
    .start  (start),
    .busy   (busy),
    .chord  (in_chord),
    .q_full (q_full),
    .push   (q_push),
    .entry  (q_wdata)
  );

  sct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  sct_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule
`default_nettype wire

[sim/tb_steno_chord_to_text.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_steno_chord_to_text
// Self-checking bench for the stenotype chord to text translator. Chords go
// in over the start/busy command port; each accepted chord is run through an
// ordered rule table kept in the bench, and every out_valid transfer is
// checked character by character, last flag included, against the text that
// chord should give. Directed chords come first, then random chords with
// changing sender gaps.
// ----------------------------------------------------------------------------
module tb_steno_chord_to_text;
  import sct_pkg::*;

  localparam logic [CHORD_W-1:0] ALL_KEYS   = 23'h7FFFFF;
  localparam logic [CHORD_W-1:0] INIT_KEYS  = K_ST | K_IS | K_IT | K_IK | K_IP | K_IW | K_IH
                                              | K_IR;
  localparam logic [CHORD_W-1:0] VOWEL_KEYS = K_A | K_O | K_E | K_U;
  localparam logic [CHORD_W-1:0] FINAL_KEYS = K_ST | K_FF | K_FR | K_FP | K_FB | K_FL | K_FG
                                              | K_FT | K_FS | K_FD | K_FZ;

  localparam int NUM_RULES        = 77;
  localparam int WHOLE_LAST       = 15;
  localparam int INIT_COMBO_FIRST = 17;
  localparam int INIT_COMBO_LAST  = 29;
  localparam int FIN_COMBO_FIRST  = 52;
  localparam int FIN_COMBO_LAST   = 66;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_xfer_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [CHORD_W-1:0] in_chord;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char_code;
  logic               out_last_char;

  char_xfer_t pending_chars[$];
  char_xfer_t want;
  int         mismatches;
  int         chords_sent;
  int         chars_checked;
  int         idle_pct;

  steno_chord_to_text u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_chord      (in_chord),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("timeout with %0d characters still expected", pending_chars.size());
    $display("Regression FAIL");
    $finish;
  end

  // rule table in priority order: key group, pattern within the group, text
  function automatic void rule_at(input int idx, output logic [CHORD_W-1:0] grp,
                                  output logic [CHORD_W-1:0] pat, output string txt);
    grp = ALL_KEYS;
    pat = '0;
    txt = "";
    case (idx)
      0:  begin pat = K_FR | K_FB | K_FG | K_FS; txt = ","; end
      1:  begin pat = K_ST; txt = "[correction]"; end
      2:  begin pat = K_IP | K_FF; txt = "[paragraph]"; end
      3:  begin pat = K_FF | K_FP | K_FL | K_FT; txt = "."; end
      4:  begin pat = K_IS | K_IT | K_IP | K_IH; txt = "?"; end
      5:  begin pat = K_IP | K_IR | K_A | K_FF; txt = "[newline]"; end
      6:  begin pat = K_NUM | K_O; txt = "0"; end
      7:  begin pat = K_NUM | K_IS; txt = "1"; end
      8:  begin pat = K_NUM | K_IT; txt = "2"; end
      9:  begin pat = K_NUM | K_IP; txt = "3"; end
      10: begin pat = K_NUM | K_IH; txt = "4"; end
      11: begin pat = K_NUM | K_A; txt = "5"; end
      12: begin pat = K_NUM | K_FF; txt = "6"; end
      13: begin pat = K_NUM | K_FP; txt = "7"; end
      14: begin pat = K_NUM | K_FL; txt = "8"; end
      15: begin pat = K_NUM | K_FT; txt = "9"; end
      16: begin grp = K_NUM; pat = K_NUM; txt = "#"; end
      17: begin grp = INIT_KEYS; pat = K_IP | K_IW; txt = "B"; end
      18: begin grp = INIT_KEYS; pat = K_IK | K_IH; txt = "CH"; end
      19: begin grp = INIT_KEYS; pat = K_IT | K_IK; txt = "D"; end
      20: begin grp = INIT_KEYS; pat = K_IT | K_IP; txt = "F"; end
      21: begin grp = INIT_KEYS; pat = K_IT | K_IK | K_IP | K_IW; txt = "G"; end
      22: begin grp = INIT_KEYS; pat = K_IS | K_IK | K_IW | K_IR; txt = "J"; end
      23: begin grp = INIT_KEYS; pat = K_IH | K_IR; txt = "L"; end
      24: begin grp = INIT_KEYS; pat = K_IP | K_IH; txt = "M"; end
      25: begin grp = INIT_KEYS; pat = K_IT | K_IP | K_IH; txt = "N"; end
      26: begin grp = INIT_KEYS; pat = K_IK | K_IW; txt = "QU"; end
      27: begin grp = INIT_KEYS; pat = K_IS | K_IR; txt = "V"; end
      28: begin grp = INIT_KEYS; pat = K_IK | K_IW | K_IR; txt = "Y"; end
      29: begin grp = INIT_KEYS; pat = K_IS | K_ST; txt = "Z"; end
      30: begin grp = K_IS; pat = K_IS; txt = "S"; end
      31: begin grp = K_IT; pat = K_IT; txt = "T"; end
      32: begin grp = K_IK; pat = K_IK; txt = "K"; end
      33: begin grp = K_IP; pat = K_IP; txt = "P"; end
      34: begin grp = K_IW; pat = K_IW; txt = "W"; end
      35: begin grp = K_IH; pat = K_IH; txt = "H"; end
      36: begin grp = K_IR; pat = K_IR; txt = "R"; end
      37: begin grp = VOWEL_KEYS; pat = K_A | K_E | K_U; txt = "ay"; end
      38: begin grp = VOWEL_KEYS; pat = K_A | K_U; txt = "aw"; end
      39: begin grp = VOWEL_KEYS; pat = K_A | K_O | K_E; txt = "ee"; end
      40: begin grp = VOWEL_KEYS; pat = K_E | K_U; txt = "i"; end
      41: begin grp = VOWEL_KEYS; pat = K_A | K_O | K_E | K_U; txt = "iy"; end
      42: begin grp = VOWEL_KEYS; pat = K_O | K_E; txt = "oh"; end
      43: begin grp = VOWEL_KEYS; pat = K_O | K_E | K_U; txt = "oi"; end
      44: begin grp = VOWEL_KEYS; pat = K_A | K_O; txt = "oo"; end
      45: begin grp = VOWEL_KEYS; pat = K_O | K_U; txt = "ou"; end
      46: begin grp = VOWEL_KEYS; pat = K_A | K_O | K_U; txt = "uu"; end
      47: begin grp = K_A; pat = K_A; txt = "a"; end
      48: begin grp = K_O; pat = K_O; txt = "o"; end
      49: begin grp = K_ST; pat = K_ST; txt = "*"; end
      50: begin grp = K_E; pat = K_E; txt = "e"; end
      51: begin grp = K_U; pat = K_U; txt = "u"; end
      52: begin grp = FINAL_KEYS; pat = K_FF | K_FP; txt = "ch"; end
      53: begin grp = FINAL_KEYS; pat = K_FP | K_FB | K_FL | K_FG; txt = "j"; end
      54: begin grp = FINAL_KEYS; pat = K_FB | K_FG; txt = "k"; end
      55: begin grp = FINAL_KEYS; pat = K_FP | K_FL; txt = "m"; end
      56: begin grp = FINAL_KEYS; pat = K_FF | K_FR | K_FP; txt = "mp"; end
      57: begin grp = FINAL_KEYS; pat = K_FP | K_FB; txt = "n"; end
      58: begin grp = FINAL_KEYS; pat = K_FP | K_FB | K_FG; txt = "ng"; end
      59: begin grp = FINAL_KEYS; pat = K_ST | K_FP | K_FB | K_FG; txt = "nk"; end
      60: begin grp = FINAL_KEYS; pat = K_FF | K_FR | K_FP | K_FB; txt = "rch"; end
      61: begin grp = FINAL_KEYS; pat = K_FF | K_FR | K_FB; txt = "rf"; end
      62: begin grp = FINAL_KEYS; pat = K_FR | K_FB; txt = "sh"; end
      63: begin grp = FINAL_KEYS; pat = K_ST | K_FF; txt = "v"; end
      64: begin grp = FINAL_KEYS; pat = K_FB | K_FG | K_FS; txt = "x"; end
      65: begin grp = FINAL_KEYS; pat = K_FG | K_FS; txt = "shun"; end
      66: begin grp = FINAL_KEYS; pat = K_ST | K_FB | K_FG | K_FS; txt = "kshun"; end
      67: begin grp = K_FF; pat = K_FF; txt = "f"; end
      68: begin grp = K_FR; pat = K_FR; txt = "r"; end
      69: begin grp = K_FP; pat = K_FP; txt = "p"; end
      70: begin grp = K_FB; pat = K_FB; txt = "b"; end
      71: begin grp = K_FL; pat = K_FL; txt = "l"; end
      72: begin grp = K_FG; pat = K_FG; txt = "g"; end
      73: begin grp = K_FT; pat = K_FT; txt = "t"; end
      74: begin grp = K_FS; pat = K_FS; txt = "s"; end
      75: begin grp = K_FD; pat = K_FD; txt = "d"; end
      76: begin grp = K_FZ; pat = K_FZ; txt = "z"; end
      default: txt = "";
    endcase
  endfunction

  // works out the text of one chord and queues its characters
  function automatic void predict_text(input logic [CHORD_W-1:0] chord);
    logic [CHORD_W-1:0] held;
    logic [CHORD_W-1:0] grp;
    logic [CHORD_W-1:0] pat;
    string              txt;
    byte                ch;
    logic [CHAR_W-1:0]  codes[$];
    char_xfer_t         x;
    held = chord & ALL_KEYS;
    for (int r = 0; r < NUM_RULES; r++) begin
      rule_at(r, grp, pat, txt);
      if ((held & grp) == pat) begin
        held &= ~grp;
        for (int i = 0; i < txt.len() && codes.size() < MAX_CHARS; i++) begin
          ch = txt[i];
          codes.push_back(ch[CHAR_W-1:0]);
        end
      end
    end
    foreach (codes[i]) begin
      x.code = codes[i];
      x.last = (i == codes.size() - 1);
      pending_chars.push_back(x);
    end
  endfunction

  function automatic logic [CHORD_W-1:0] random_chord();
    logic [CHORD_W-1:0] c;
    logic [CHORD_W-1:0] grp;
    logic [CHORD_W-1:0] pat;
    string              txt;
    int                 mode;
    int                 bitpos;
    mode = $urandom_range(99);
    c = '0;
    if (mode < 15) begin
      // whole-chord pattern, sometimes with one key flipped
      rule_at($urandom_range(WHOLE_LAST), grp, pat, txt);
      c = pat;
      if ($urandom_range(3) == 0) begin
        bitpos = $urandom_range(CHORD_W - 1);
        c[bitpos] = ~c[bitpos];
      end
    end else if (mode < 40) begin
      c = CHORD_W'($urandom());
    end else if (mode < 50) begin
      bitpos = $urandom_range(CHORD_W - 1);
      c[bitpos] = 1'b1;
      bitpos = $urandom_range(CHORD_W - 1);
      c[bitpos] = 1'b1;
    end else begin
      // word-like chord: initial, vowel and final parts
      if ($urandom_range(9) < 7) begin
        rule_at($urandom_range(INIT_COMBO_LAST, INIT_COMBO_FIRST), grp, pat, txt);
        c |= pat;
      end else begin
        c |= CHORD_W'($urandom()) & INIT_KEYS & ~K_ST;
      end
      c |= CHORD_W'($urandom()) & VOWEL_KEYS;
      if ($urandom_range(9) < 7) begin
        rule_at($urandom_range(FIN_COMBO_LAST, FIN_COMBO_FIRST), grp, pat, txt);
        c |= pat;
      end else begin
        c |= CHORD_W'($urandom()) & FINAL_KEYS & ~K_ST;
      end
      if ($urandom_range(4) == 0) c |= K_ST;
      if ($urandom_range(9) == 0) c |= K_NUM;
    end
    return c;
  endfunction

  // called right after a falling edge, returns right after a falling edge once the chord is taken
  task automatic send_chord(input logic [CHORD_W-1:0] chord);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(8, 1) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    = 1'b1;
    in_chord = chord;
    do @(posedge clk); while (busy);
    predict_text(chord);
    chords_sent++;
    @(negedge clk);
  endtask

  task automatic wait_text_drained();
    start = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  task automatic test_special_chords();
    logic [CHORD_W-1:0] grp;
    logic [CHORD_W-1:0] pat;
    string              txt;
    idle_pct = 0;
    send_chord('0);
    send_chord(ALL_KEYS);
    for (int r = 0; r <= WHOLE_LAST; r++) begin
      rule_at(r, grp, pat, txt);
      send_chord(pat);
    end
    send_chord(K_NUM);
    send_chord(K_IS | K_ST);
    send_chord(K_ST | K_FB | K_FG | K_FS);
    send_chord(K_IS | K_IK | K_IW | K_IR | K_A | K_E | K_U | K_FF | K_FR | K_FP | K_FB);
    send_chord(K_NUM | K_O | K_E);
    send_chord(K_FZ);
    wait_text_drained();
  endtask

  task automatic test_random_chords(input int count, input int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      send_chord(random_chord());
      // hold off until all text is out, once mid-phase
      if (i == count / 2) wait_text_drained();
    end
    wait_text_drained();
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected character 0x%0h last=%0b", out_char_code, out_last_char);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_char_code !== want.code || out_last_char !== want.last) begin
          if (mismatches < 10)
            $display("character mismatch: expected 0x%0h last=%0b, got 0x%0h last=%0b",
                     want.code, want.last, out_char_code, out_last_char);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_chord      = '0;
    idle_pct      = 0;
    mismatches    = 0;
    chords_sent   = 0;
    chars_checked = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_special_chords();
    test_random_chords(140, 0);
    test_random_chords(140, 65);
    test_random_chords(106, 10);

    repeat (30) @(negedge clk);
    $display("%0d chords sent (directed and random, with and without sender gaps)",
             chords_sent);
    $display("%0d characters checked, %0d mismatches", chars_checked, mismatches);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
